// ===== rtl/cbu_pkg.sv =====
`timescale 1ns / 1ps

package cbu_pkg;

    localparam int FRAC_BITS_DEF = 20;
    localparam int ENTRY_W       = 24;
    localparam int NUM_ENTRIES   = 8;
    localparam int IDX_W         = $clog2(NUM_ENTRIES);
    localparam int SUM_W         = ENTRY_W + IDX_W;
    localparam int ACC_W         = ENTRY_W + 2;
    localparam int CFG_IDX_W     = 4;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [SUM_W-1:0]   t_sum;

    localparam t_entry ENTRY_MAX = '1;

    localparam t_entry POT_RESET [NUM_ENTRIES] = '{
        t_entry'(31457),  t_entry'(1573),   t_entry'(20972),  t_entry'(3670),
        t_entry'(283116), t_entry'(155714), t_entry'(188744), t_entry'(363332)
    };

    typedef enum logic {
        CMD_FWD = 1'b0,
        CMD_BWD = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FWD   = 2'd1,
        ST_ZERO_SUM = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd   command;
        t_entry msg_a;
        t_entry msg_b;
        t_entry msg_c;
        t_entry msg_d;
    } t_in_req;

    typedef struct packed {
        t_entry  out_a;
        t_entry  out_b;
        t_entry  out_c;
        t_entry  out_d;
        t_status status;
    } t_out_req;

endpackage

// ===== rtl/clique_belief_update.sv =====
// A forward or backward item runs the bit-serial multiplier and then the bit-serial divider
// over all 8 entries before its result is valid; a zero table sum skips the divider, and a
// backward item before any forward item goes straight to the result. The block takes no new
// item until the result of the last one has been loaded (o_in_stall is high outside idle).
// Reset restores the default potentials and clears the forward flag and the output valid.
`timescale 1ns / 1ps

module clique_belief_update import cbu_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_req             o_out_req,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_entry               i_cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    t_state           r_state;
    t_state           n_state;
    logic             r_fwd_seen;
    logic             r_out_valid;
    t_out_req         r_out;
    t_in_req          r_req;
    t_status          r_status;
    logic [IDX_W-1:0] r_k;
    t_sum             r_sum;
    logic [ACC_W-1:0] r_acc [4];
    t_entry           r_pot [NUM_ENTRIES];
    t_entry           r_tab [NUM_ENTRIES];

    logic             in_accept;
    logic             mul_start;
    logic             div_start;
    logic             out_load;
    logic             mul_done;
    logic             div_done;
    t_entry           mul_result;
    t_entry           div_result;
    t_entry           weight;
    t_sum             sum_next;
    logic [1:0]       acc_sel;

    function automatic t_entry sat_acc(input logic [ACC_W-1:0] value);
        return (|value[ACC_W-1:ENTRY_W]) ? ENTRY_MAX : value[ENTRY_W-1:0];
    endfunction

    assign in_accept = (r_state == S_IDLE) && i_in_valid;
    assign sum_next  = r_sum + SUM_W'(mul_result);
    assign acc_sel   = (r_req.command == CMD_FWD) ? r_k[2:1] : {1'b0, r_k[1]};

    always_comb begin
        if (r_req.command == CMD_FWD) begin
            weight = r_k[1] ? r_req.msg_b : r_req.msg_a;
        end else begin
            unique case (r_k[2:1])
                2'd0:    weight = r_req.msg_a;
                2'd1:    weight = r_req.msg_b;
                2'd2:    weight = r_req.msg_c;
                default: weight = r_req.msg_d;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_req.command == CMD_BWD && !r_fwd_seen) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_MUL_GO: begin
                mul_start = 1'b1;
                n_state   = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    if (r_k != LAST_IDX) begin
                        n_state = S_MUL_GO;
                    end else if (sum_next == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_k == LAST_IDX) ? S_DONE : S_DIV_GO;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fwd_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept && i_in_req.command == CMD_FWD) begin
                r_fwd_seen <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot <= POT_RESET;
        end else if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(NUM_ENTRIES)) begin
            r_pot[i_cfg_index[IDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req  <= i_in_req;
            r_k    <= '0;
            r_sum  <= '0;
            r_acc  <= '{default: '0};
            if (i_in_req.command == CMD_FWD) begin
                r_tab <= r_pot;
            end
            r_status <= (i_in_req.command == CMD_BWD && !r_fwd_seen) ? ST_NO_FWD : ST_OK;
        end else if (r_state == S_MUL_WAIT && mul_done) begin
            r_tab[r_k] <= mul_result;
            r_sum      <= sum_next;
            r_k        <= r_k + 1'b1;
            if (r_k == LAST_IDX && sum_next == '0) begin
                r_status <= ST_ZERO_SUM;
            end
        end else if (r_state == S_DIV_WAIT && div_done) begin
            r_tab[r_k]     <= div_result;
            r_acc[acc_sel] <= r_acc[acc_sel] + ACC_W'(div_result);
            r_k            <= r_k + 1'b1;
        end
        if (out_load) begin
            r_out.out_a  <= sat_acc(r_acc[0]);
            r_out.out_b  <= sat_acc(r_acc[1]);
            r_out.out_c  <= sat_acc(r_acc[2]);
            r_out.out_d  <= sat_acc(r_acc[3]);
            r_out.status <= r_status;
        end
    end

    cbu_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (r_tab[r_k]),
        .i_mplier (weight),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    cbu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tab[r_k]),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quotient (div_result)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/cbu_mul.sv =====
`timescale 1ns / 1ps

module cbu_mul import cbu_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_entry i_mcand,
    input  t_entry i_mplier,
    output logic   o_done,
    output t_entry o_result
);

    localparam int PROD_W = 2 * ENTRY_W;
    localparam int CNT_W  = $clog2(ENTRY_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_entry            r_mcand;
    t_entry            r_mplier;
    logic [PROD_W-1:0] r_prod;
    logic [ENTRY_W:0]  w_upper;
    logic [PROD_W-1:0] w_shift;

    // One multiplier bit per cycle, least significant first.
    assign w_upper = {1'b0, r_prod[PROD_W-1:ENTRY_W]}
                   + (r_mplier[0] ? {1'b0, r_mcand} : '0);
    assign w_shift = r_prod >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(ENTRY_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt    <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_prod   <= '0;
        end else if (r_busy) begin
            r_cnt    <= r_cnt + 1'b1;
            r_mplier <= r_mplier >> 1;
            r_prod   <= {w_upper, r_prod[ENTRY_W-1:1]};
        end
    end

    assign o_done   = r_done;
    assign o_result = (|w_shift[PROD_W-1:ENTRY_W]) ? ENTRY_MAX : w_shift[ENTRY_W-1:0];

endmodule

// ===== rtl/cbu_div.sv =====
`timescale 1ns / 1ps

module cbu_div import cbu_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_entry i_dividend,
    input  t_sum   i_divisor,
    output logic   o_done,
    output t_entry o_quotient
);

    localparam int QN    = FRAC_BITS + IDX_W + 1;
    localparam int QW    = (QN > ENTRY_W) ? QN : ENTRY_W + 1;
    localparam int CNT_W = $clog2(QN);
    localparam int REM_W = SUM_W + 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    t_sum             r_div;
    logic [QW-1:0]    r_quo;
    logic             w_ge;
    logic [REM_W-1:0] w_diff;
    logic [REM_W-1:0] w_keep;

    // The dividend never exceeds the divisor, so the quotient has QN bits and the
    // remainder stays below twice the divisor.
    assign w_ge   = r_rem >= {1'b0, r_div};
    assign w_diff = r_rem - {1'b0, r_div};
    assign w_keep = w_ge ? w_diff : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(QN - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= REM_W'(i_dividend);
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= {w_keep[REM_W-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = (|r_quo[QW-1:ENTRY_W]) ? ENTRY_MAX : r_quo[ENTRY_W-1:0];

endmodule

// ===== dv/tb_clique_belief_update.sv =====
`timescale 1ns / 1ps

module tb_clique_belief_update;
    import cbu_pkg::*;

    localparam int unsigned LONG_HOLD      = 2500;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 450;
    localparam int unsigned RANDOM_ITEMS   = 150;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_req              in_req = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_entry               cfg_data = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_req             o_out_req;
    logic                 o_cfg_ready;

    t_in_req              pending_requests [$];
    t_out_req             expected_marginals [$];

    t_entry               potential_cfg [NUM_ENTRIES];
    t_entry               clique_table [NUM_ENTRIES];
    bit                   forward_done = 1'b0;

    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct = 0;
    int unsigned          hold_requests = 0;
    int unsigned          holds_served = 0;
    int unsigned          hold_left = 0;
    int unsigned          idle_cycles = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          result_count = 0;

    clique_belief_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_entry sat_entry(logic [63:0] v);
        return (v > 64'(ENTRY_MAX)) ? ENTRY_MAX : t_entry'(v);
    endfunction

    // Each pair of entries (0,1), (2,3), (4,5), (6,7) shares one weight.
    function automatic bit weigh_normalize(t_entry w0, t_entry w1, t_entry w2, t_entry w3);
        logic [63:0] total;
        logic [63:0] prod;
        t_entry      w;
        total = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            case (i >> 1)
                0: w = w0;
                1: w = w1;
                2: w = w2;
                default: w = w3;
            endcase
            prod = (64'(clique_table[i]) * 64'(w)) >> FRAC_BITS_DEF;
            clique_table[i] = sat_entry(prod);
            total += 64'(clique_table[i]);
        end
        if (total == 0) begin
            return 1'b0;
        end
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            clique_table[i] = sat_entry(((64'(clique_table[i]) * 8) << FRAC_BITS_DEF) / total);
        end
        return 1'b1;
    endfunction

    function automatic t_out_req predict_marginals(t_in_req req);
        t_out_req r;
        r = '0;
        r.status = ST_OK;
        if (req.command == CMD_FWD) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                clique_table[i] = potential_cfg[i];
            end
            forward_done = 1'b1;
            if (!weigh_normalize(req.msg_a, req.msg_b, req.msg_a, req.msg_b)) begin
                r.status = ST_ZERO_SUM;
            end else begin
                r.out_a = sat_entry(64'(clique_table[0]) + 64'(clique_table[1]));
                r.out_b = sat_entry(64'(clique_table[2]) + 64'(clique_table[3]));
                r.out_c = sat_entry(64'(clique_table[4]) + 64'(clique_table[5]));
                r.out_d = sat_entry(64'(clique_table[6]) + 64'(clique_table[7]));
            end
        end else if (!forward_done) begin
            r.status = ST_NO_FWD;
        end else if (!weigh_normalize(req.msg_a, req.msg_b, req.msg_c, req.msg_d)) begin
            r.status = ST_ZERO_SUM;
        end else begin
            r.out_a = sat_entry(64'(clique_table[0]) + 64'(clique_table[1])
                                + 64'(clique_table[4]) + 64'(clique_table[5]));
            r.out_b = sat_entry(64'(clique_table[2]) + 64'(clique_table[3])
                                + 64'(clique_table[6]) + 64'(clique_table[7]));
        end
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [ENTRY_W-1:0] got, logic [ENTRY_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch in %s of result %0d: expected %h, got %h",
                     field, result_count, want, got);
        end
    endtask

    task automatic check_result(t_out_req got);
        t_out_req want;
        if (expected_marginals.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d arrived with no request outstanding: %h",
                         result_count, got);
            end
        end else begin
            want = expected_marginals.pop_front();
            if (got.out_a !== want.out_a) flag_mismatch("out_a", got.out_a, want.out_a);
            if (got.out_b !== want.out_b) flag_mismatch("out_b", got.out_b, want.out_b);
            if (got.out_c !== want.out_c) flag_mismatch("out_c", got.out_c, want.out_c);
            if (got.out_d !== want.out_d) flag_mismatch("out_d", got.out_d, want.out_d);
            if (got.status !== want.status) begin
                flag_mismatch("status", ENTRY_W'(got.status), ENTRY_W'(want.status));
            end
        end
        result_count++;
    endtask

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_marginals.push_back(predict_marginals(in_req));
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_req <= pending_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                check_result(o_out_req);
            end
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_entry pick_message();
        case ($urandom_range(7))
            0: return '0;
            1: return ENTRY_MAX;
            2: return t_entry'(1 << FRAC_BITS_DEF);
            3, 4: return t_entry'($urandom_range(0, 2 << FRAC_BITS_DEF));
            default: return t_entry'($urandom);
        endcase
    endfunction

    function automatic t_entry pick_potential();
        case ($urandom_range(5))
            0: return '0;
            1: return ENTRY_MAX;
            2, 3: return t_entry'($urandom_range(0, 1 << (FRAC_BITS_DEF - 1)));
            default: return t_entry'($urandom);
        endcase
    endfunction

    function automatic t_in_req make_request(t_cmd cmd);
        t_in_req r;
        r.command = cmd;
        r.msg_a = pick_message();
        r.msg_b = pick_message();
        r.msg_c = pick_message();
        r.msg_d = pick_message();
        return r;
    endfunction

    task automatic push_req(t_cmd cmd, t_entry a, t_entry b, t_entry c, t_entry d);
        t_in_req r;
        r.command = cmd;
        r.msg_a = a;
        r.msg_b = b;
        r.msg_c = c;
        r.msg_d = d;
        pending_requests.push_back(r);
    endtask

    // Mostly a forward request followed by a few backward ones, with an occasional
    // stray backward request against whatever table is left.
    task automatic queue_random(int unsigned count);
        int unsigned queued;
        int unsigned backs;
        queued = 0;
        @(negedge i_clk);
        while (queued < count) begin
            if ($urandom_range(7) != 0) begin
                pending_requests.push_back(make_request(CMD_FWD));
                queued++;
            end
            backs = $urandom_range(0, 3);
            for (int k = 0; k < backs; k++) begin
                pending_requests.push_back(make_request(CMD_BWD));
                queued++;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || in_valid || expected_marginals.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_potential(logic [CFG_IDX_W-1:0] idx, t_entry value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx < NUM_ENTRIES) begin
            potential_cfg[idx[IDX_W-1:0]] = value;
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            potential_cfg[i] = POT_RESET[i];
            clique_table[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // Default potentials: backward requests before any forward one, unit
        // weights, zero weights, and a forward pass that leaves an all-zero table.
        @(negedge i_clk);
        push_req(CMD_BWD, ENTRY_MAX, '0, ENTRY_MAX, '0);
        push_req(CMD_BWD, '0, ENTRY_MAX, '0, ENTRY_MAX);
        push_req(CMD_FWD, t_entry'(1 << FRAC_BITS_DEF), t_entry'(1 << FRAC_BITS_DEF), '0, '0);
        push_req(CMD_BWD, t_entry'(1 << FRAC_BITS_DEF), t_entry'(1 << FRAC_BITS_DEF),
                 t_entry'(1 << FRAC_BITS_DEF), t_entry'(1 << FRAC_BITS_DEF));
        push_req(CMD_BWD, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX);
        push_req(CMD_FWD, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX);
        push_req(CMD_BWD, '0, '0, '0, '0);
        push_req(CMD_BWD, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX);
        push_req(CMD_FWD, '0, '0, ENTRY_MAX, ENTRY_MAX);
        push_req(CMD_FWD, '0, t_entry'(1 << FRAC_BITS_DEF), '0, '0);
        push_req(CMD_BWD, t_entry'(1 << FRAC_BITS_DEF), '0, ENTRY_MAX, t_entry'(1));
        push_req(CMD_FWD, t_entry'(1), t_entry'(1), '0, '0);
        push_req(CMD_FWD, t_entry'(16), t_entry'(16), '0, '0);
        wait_drained();

        for (int i = 0; i < NUM_ENTRIES; i++) begin
            write_potential(CFG_IDX_W'(i), ENTRY_MAX);
        end
        @(negedge i_clk);
        push_req(CMD_FWD, ENTRY_MAX, ENTRY_MAX, '0, '0);
        push_req(CMD_BWD, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX);
        push_req(CMD_FWD, t_entry'(1 << FRAC_BITS_DEF), ENTRY_MAX, '0, '0);
        push_req(CMD_BWD, '0, ENTRY_MAX, '0, ENTRY_MAX);
        wait_drained();

        // Indexes past the table must leave the potentials alone.
        write_potential(CFG_IDX_W'(8), t_entry'($urandom));
        write_potential(CFG_IDX_W'(15), t_entry'($urandom));
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            write_potential(CFG_IDX_W'(i), '0);
        end
        @(negedge i_clk);
        push_req(CMD_FWD, ENTRY_MAX, ENTRY_MAX, '0, '0);
        push_req(CMD_BWD, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                write_potential(CFG_IDX_W'(i), pick_potential());
            end
            write_potential(CFG_IDX_W'($urandom_range(NUM_ENTRIES, 15)), t_entry'($urandom));
            queue_random(RANDOM_ITEMS);
            wait_drained();
        end

        // Hold the result side off while requests keep coming, so the block backs up.
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        queue_random(8);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_marginals.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
